/* design/sapq_pkg.sv */
// Package for the sorted-array priority queue: sizes, codes, payload and
// controller types. Depends on nothing; every other design file uses it.
`default_nettype none

package sapq_pkg;

  // Number of cells in the chain, and the width of the live-entry count.
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Request kinds.
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  // One request.
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } in_item_t;

  // One result.
  typedef struct packed {
    status_t            status;
    logic signed [31:0] head_value;
    logic signed [31:0] head_priority;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic               is_full;
  } out_item_t;

  // Controller states.
  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_EXEC = 1'b1
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic execute;
  } ctl_cmd_t;

endpackage

`default_nettype wire

/* design/sapq_ctl.sv */
// Controller for the priority queue: accepts a request, then runs it
// through the datapath when the result register is free. Uses sapq_pkg.
`default_nettype none

module sapq_ctl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sapq_pkg::ctl_cmd_t     cmd
);

  sapq_pkg::ctl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  // Hold state and result-valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sapq_pkg::CTL_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      sapq_pkg::CTL_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = sapq_pkg::CTL_EXEC;
        end
      end
      sapq_pkg::CTL_EXEC: begin
        // Run only when the result register can take the outcome.
        if (out_free) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sapq_pkg::CTL_IDLE;
        end
      end
      default: state_nxt = sapq_pkg::CTL_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* design/sapq_dp.sv */
// Datapath for the priority queue: request register, sorted cell chain,
// entry count and result register. Uses sapq_pkg.
`default_nettype none

module sapq_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sapq_pkg::ctl_cmd_t  cmd,
  input  wire sapq_pkg::in_item_t  in_item,
  output sapq_pkg::out_item_t      out_item
);

  localparam int N     = sapq_pkg::CAPACITY;
  localparam int CNT_W = sapq_pkg::CNT_W;

  sapq_pkg::in_item_t  item_r;
  sapq_pkg::out_item_t out_r, out_nxt;

  logic signed [31:0] val_r [N];
  logic signed [31:0] pri_r [N];
  logic signed [31:0] val_nxt [N];
  logic signed [31:0] pri_nxt [N];
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic [N-1:0] gt;
  logic         is_full_now;
  logic         is_empty_now;
  logic         do_insert;
  logic         do_remove;

  // Capture the request.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
  end

  // Each live cell compares its priority with the new one; the cells that
  // stay ahead of the new pair form a prefix of the chain.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt[i] = (count_r > CNT_W'(i)) && (pri_r[i] > item_r.item_priority);
    end
  end

  assign is_full_now  = (count_r == CNT_W'(N));
  assign is_empty_now = (count_r == '0);
  assign do_insert    = (item_r.kind == sapq_pkg::KIND_INSERT) && !is_full_now;
  assign do_remove    = (item_r.kind == sapq_pkg::KIND_REMOVE) && !is_empty_now;

  // Next contents of every cell: keep, take the new pair, or shift.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
      if (do_insert && !gt[i]) begin
        if (i == 0) begin
          val_nxt[i] = item_r.item_value;
          pri_nxt[i] = item_r.item_priority;
        end else if (gt[(i > 0) ? i - 1 : 0]) begin
          val_nxt[i] = item_r.item_value;
          pri_nxt[i] = item_r.item_priority;
        end else begin
          val_nxt[i] = val_r[(i > 0) ? i - 1 : 0];
          pri_nxt[i] = pri_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_remove && (i < N - 1)) begin
        val_nxt[i] = val_r[(i < N - 1) ? i + 1 : i];
        pri_nxt[i] = pri_r[(i < N - 1) ? i + 1 : i];
      end
    end
  end

  // Count after this request.
  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Build the result.
  always_comb begin
    out_nxt               = '0;
    out_nxt.status        = sapq_pkg::STAT_OK;
    if (item_r.kind == sapq_pkg::KIND_INSERT) begin
      if (is_full_now) begin
        out_nxt.status = sapq_pkg::STAT_OVERFLOW;
      end
    end else begin
      if (is_empty_now) begin
        out_nxt.status = sapq_pkg::STAT_UNDERFLOW;
      end else begin
        out_nxt.head_value    = val_r[0];
        out_nxt.head_priority = pri_r[0];
      end
    end
    out_nxt.entry_count = 5'(count_nxt);
    out_nxt.is_empty    = (count_nxt == '0);
    out_nxt.is_full     = (count_nxt == CNT_W'(N));
  end

  // Advance the cell chain and the result register.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < N; i++) begin
        val_r[i] <= val_nxt[i];
        pri_r[i] <= pri_nxt[i];
      end
      out_r <= out_nxt;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

/* design/sorted_array_priority_queue_unit.sv */
// Top level of the sorted-array priority queue: controller plus datapath.
// Depends on sapq_pkg, sapq_ctl and sapq_dp.
//
// Usage:
//   Requests arrive on in_valid/in_ready/in_item: kind selects insert or
//   remove-head; value and priority matter only for an insert. Each request
//   yields exactly one result on out_valid/out_ready/out_item with a status
//   (ok, overflow, underflow), the removed head (zero unless a remove
//   succeeded), the entry count after the request and empty/full flags.
//   Equal priorities are served newest first.
//   A transferred request is held in the request register by the
//   controller's capture state and runs once the result register is free;
//   no new request is taken until then. When it runs, all 16 cells
//   compare with the new priority and shift in parallel.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result. While the receiver stalls, the result holds; one more request
//   can be transferred and waits until the result register frees up.
`default_nettype none

module sorted_array_priority_queue_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sapq_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sapq_pkg::out_item_t      out_item
);

  sapq_pkg::ctl_cmd_t cmd;

  sapq_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sapq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

/* design/sapq_checker.sv */
// Port-level checks for the priority queue, bound to the top level.
// Depends on sapq_pkg and sorted_array_priority_queue_unit.
`default_nettype none

module sapq_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire sapq_pkg::out_item_t out_item
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // After a transfer in, the block takes no request in the next cycle.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken on consecutive cycles");

  // Overflow only when full, underflow only when empty.
  a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_item.status != sapq_pkg::STAT_OVERFLOW || out_item.is_full) &&
      (out_item.status != sapq_pkg::STAT_UNDERFLOW || out_item.is_empty))
    else $error("error status disagrees with flags");

  // Empty flag tracks the count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.is_empty == (out_item.entry_count == 5'd0))
    else $error("empty flag disagrees with count");

  // A failed request returns no head.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != sapq_pkg::STAT_OK |->
      out_item.head_value == 32'sd0 && out_item.head_priority == 32'sd0)
    else $error("failed request returned a head");

endmodule

bind sorted_array_priority_queue_unit sapq_checker u_sapq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

/* sim/priority_queue_monitor.sv */
// Transfer monitor for the sorted-array priority queue: keeps its own sorted
// copy of the queue, predicts each result and compares it field by field.
// Depends on sapq_pkg for the payload types, status and kind codes.

module priority_queue_monitor
  import sapq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        mismatches,
  output int        outstanding
);

  // Shadow queue, slot 0 is the head, kept in descending priority order.
  logic signed [31:0] held_value    [CAPACITY];
  logic signed [31:0] held_priority [CAPACITY];
  int                 held_count;

  out_item_t awaited_results [$];
  int        fail_total = 0;

  // Apply one request to the shadow queue and return the result it yields.
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t res;
    int        pos;
    int        k;
    res        = '0;
    res.status = STAT_OK;
    if (req.kind == KIND_INSERT) begin
      if (held_count >= CAPACITY) begin
        res.status = STAT_OVERFLOW;
      end else begin
        // Go ahead of the first entry whose priority is not above the new one.
        pos = 0;
        while (pos < held_count && held_priority[pos] > req.item_priority) pos++;
        for (k = held_count; k > pos; k--) begin
          held_value[k]    = held_value[k-1];
          held_priority[k] = held_priority[k-1];
        end
        held_value[pos]    = req.item_value;
        held_priority[pos] = req.item_priority;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = STAT_UNDERFLOW;
      end else begin
        res.head_value    = held_value[0];
        res.head_priority = held_priority[0];
        for (k = 1; k < held_count; k++) begin
          held_value[k-1]    = held_value[k];
          held_priority[k-1] = held_priority[k];
        end
        held_count--;
      end
    end
    res.entry_count = 5'(held_count);
    res.is_empty    = (held_count == 0);
    res.is_full     = (held_count == CAPACITY);
    return res;
  endfunction

  function automatic int field_diff(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Check the result side first, then queue the prediction for a new request,
  // so a transfer on both channels at one edge matches the older request.
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      held_count = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0h", $realtime, out_item);
          fail_total++;
        end else begin
          want = awaited_results.pop_front();
          fail_total += field_diff("status", want.status, out_item.status);
          fail_total += field_diff("head_value", want.head_value, out_item.head_value);
          fail_total += field_diff("head_priority", want.head_priority,
                                   out_item.head_priority);
          fail_total += field_diff("entry_count", want.entry_count, out_item.entry_count);
          fail_total += field_diff("is_empty", want.is_empty, out_item.is_empty);
          fail_total += field_diff("is_full", want.is_full, out_item.is_full);
        end
      end
      if (in_valid && in_ready) awaited_results.push_back(apply_request(in_item));
    end
    mismatches  <= fail_total;
    outstanding <= awaited_results.size();
  end

endmodule

/* sim/tb_sorted_array_priority_queue_unit.sv */
// Testbench top for the sorted-array priority queue: drives requests and the
// result-side ready, then reports the verdict from priority_queue_monitor.
// Depends on sapq_pkg, sorted_array_priority_queue_unit and the monitor.

module tb_sorted_array_priority_queue_unit;
  import sapq_pkg::*;

  localparam int RANDOM_PER_PHASE = 627;
  localparam int LONG_STALL       = 150;
  localparam int DRAIN_CYCLES     = 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  // Idle phase: 0 sender light / receiver heavy, 1 the reverse, 2 no idling.
  int phase      = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;
  int mismatches;
  int outstanding;

  initial begin
    forever #5 clk = ~clk;
  end

  sorted_array_priority_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  priority_queue_monitor monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver: random stalls by phase; one long hold-off when phase 2 opens
  // so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (phase == 2 && !stall_done) begin
      stall_left <= LONG_STALL;
      stall_done <= 1'b1;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= ((phase == 0) ? 86 : (phase == 1) ? 26 : 0));
    end
  end

  // Mix of small priorities for ties, the extremes, and full-range values.
  function automatic logic signed [31:0] pick_priority();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed($urandom_range(8)) - 4;
      4, 5: begin
        case ($urandom_range(3))
          0:       return 32'sh7fffffff;
          1:       return $signed(32'h80000000);
          2:       return 0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Offer one request after a random gap and hold it until the transfer.
  task automatic send_req(input kind_t kind, input logic [31:0] item_val,
                          input logic [31:0] item_pri);
    in_item_t req;
    req.kind          = kind;
    req.item_value    = item_val;
    req.item_priority = item_pri;
    while ($urandom_range(99) < ((phase == 0) ? 26 : (phase == 1) ? 86 : 0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin : stimulus
    int           i;
    int           p;
    int           n;
    int           run_left;
    int           insert_share;
    logic [31:0]  dir_val;
    logic [31:0]  dir_pri;
    run_left     = 0;
    insert_share = 50;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Remove from an empty queue.
    send_req(KIND_REMOVE, $urandom, $urandom);
    // Fill with extremes and equal priorities, newest of a tie served first.
    for (i = 0; i < CAPACITY; i++) begin
      case (i)
        0:       begin dir_val = 32'h7fffffff; dir_pri = 32'h7fffffff; end
        1:       begin dir_val = 32'h80000000; dir_pri = 32'h80000000; end
        2:       begin dir_val = 32'h00000000; dir_pri = 32'h00000000; end
        3:       begin dir_val = 32'hffffffff; dir_pri = 32'hffffffff; end
        4:       begin dir_val = 32'd4;        dir_pri = 32'h00000000; end
        5:       begin dir_val = 32'd5;        dir_pri = 32'h7fffffff; end
        6:       begin dir_val = 32'd6;        dir_pri = 32'h80000000; end
        default: begin dir_val = $urandom;     dir_pri = (i % 5) - 2;  end
      endcase
      send_req(KIND_INSERT, dir_val, dir_pri);
    end
    // Insert into a full queue, then take a few heads.
    send_req(KIND_INSERT, $urandom, 32'h7fffffff);
    for (i = 0; i < 4; i++) send_req(KIND_REMOVE, $urandom, $urandom);

    // Random runs that lean toward inserts, removes, or neither, so the
    // queue swings between empty and full.
    for (p = 0; p < 3; p++) begin
      phase <= p;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(40, 4);
          case ($urandom_range(2))
            0:       insert_share = 85;
            1:       insert_share = 15;
            default: insert_share = 50;
          endcase
        end
        run_left--;
        send_req(($urandom_range(99) < insert_share) ? KIND_INSERT : KIND_REMOVE,
                 $urandom, pick_priority());
      end
    end

    // Drain the results still in flight.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_sorted_array_priority_queue_unit OK");
    end else begin
      $display("tb_sorted_array_priority_queue_unit NOT OK");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #5000000;
    $display("tb_sorted_array_priority_queue_unit NOT OK");
    $finish;
  end

endmodule

/* files.f */
design/sapq_pkg.sv
design/sapq_ctl.sv
design/sapq_dp.sv
design/sorted_array_priority_queue_unit.sv
design/sapq_checker.sv
sim/priority_queue_monitor.sv
sim/tb_sorted_array_priority_queue_unit.sv
